/* src/ffrp_pkg.sv */
// Shared types and codes for the first-fit rectangle placer.
`default_nettype none
package ffrp_pkg;

  localparam logic [1:0] OP_BEGIN   = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_PLACE   = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam int CFG_W = 6;
  localparam int POS_W = 8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rect_x;
    logic [7:0] rect_y;
    logic [8:0] rect_w;
    logic [8:0] rect_h;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [4:0] page_index;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [4:0] added_pages;
  } out_item_t;

  // status of the span search unit
  typedef struct packed {
    logic             done;
    logic             found;
    logic [POS_W-1:0] pos;
  } span_stat_t;

endpackage
`default_nettype wire

/* src/first_fit_rectangle_placer.sv */
// Top level: sequencer, occupancy and free-space memories, span search unit.
// One item at a time. Begin clears a page, one row per cycle. Reserve reads and
// rewrites each marked row. Place, for each candidate row position y on each
// scanned page, reads rect_h occupancy rows (one occupancy row per cycle) and
// then runs the window shift steps and chunk scan steps in the span unit; every
// page brought into use is cleared first, and the final mark reads and rewrites
// each row. The single occupancy read port and the span unit set the rate.
// Results sit in an output register, so a new item is taken while the last
// result waits.
`default_nettype none
module first_fit_rectangle_placer #(
  parameter int MAX_PAGES = 32,
  parameter int PAGE_DIM  = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire ffrp_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ffrp_pkg::out_item_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [ffrp_pkg::CFG_W-1:0] cfg_data
);

  localparam int PW        = $clog2(MAX_PAGES + 1);
  localparam int PI        = $clog2(MAX_PAGES);
  localparam int RI        = $clog2(PAGE_DIM);
  localparam int AW        = $clog2(MAX_PAGES * PAGE_DIM);
  localparam int PAGE_AREA = PAGE_DIM * PAGE_DIM;
  localparam int FSW       = $clog2(PAGE_AREA + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_PAGE = 4'd2;
  localparam logic [3:0] S_CLR  = 4'd3;
  localparam logic [3:0] S_BRFS = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_ROW  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_SPAN = 4'd9;
  localparam logic [3:0] S_MCHK = 4'd10;
  localparam logic [3:0] S_MRD  = 4'd11;
  localparam logic [3:0] S_MWR  = 4'd12;
  localparam logic [3:0] S_RFS  = 4'd13;
  localparam logic [3:0] S_RFSW = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0]                 state;
  logic [ffrp_pkg::CFG_W-1:0] lpc;
  logic [ffrp_pkg::CFG_W-1:0] start_pg;
  logic [1:0]                 op;
  logic [7:0]                 rx, ry;
  logic [8:0]                 rw, rh;
  logic [17:0]                area;
  logic [PW-1:0]              pages;
  logic [PW-1:0]              i;
  logic [9:0]                 y, cnt, mrow, mend, mx, mxe;
  logic                       pend;
  logic [PAGE_DIM-1:0]        c;
  logic [PAGE_DIM-1:0]        mask;
  logic                       r_status;
  logic [4:0]                 r_page;
  logic [7:0]                 r_x, r_y;
  logic [9:0]                 row_sum;
  logic                       pg_end;

  logic                       occ_we;
  logic [AW-1:0]              occ_waddr, occ_raddr;
  logic [PAGE_DIM-1:0]        occ_wdata, occ_rdata;
  logic                       fs_we;
  logic [FSW-1:0]             fs_wdata, fs_rdata;
  logic                       sp_start;
  ffrp_pkg::span_stat_t       sp_stat;

  function automatic logic [AW-1:0] row_addr(input logic [PI-1:0] pg,
                                             input logic [RI-1:0] row);
    return AW'(pg) * AW'(PAGE_DIM) + AW'(row);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign start_pg  = (lpc == '0) ? '0 : lpc - 1'b1;
  assign pg_end    = ({2'b0, start_pg} + 8'(i)) >= 8'(MAX_PAGES);
  assign row_sum   = y + cnt;
  assign sp_start  = (state == S_ACC) && (cnt >= {1'b0, rh}) && !pend;

  always_comb begin
    for (int b = 0; b < PAGE_DIM; b++) begin
      mask[b] = (10'(b) >= mx) && (10'(b) < mxe);
    end
  end

  always_comb begin
    occ_we    = (state == S_CLR) || (state == S_MWR);
    occ_waddr = (state == S_CLR) ? row_addr(i[PI-1:0], cnt[RI-1:0])
                                 : row_addr(i[PI-1:0], mrow[RI-1:0]);
    occ_wdata = (state == S_CLR) ? '0 : (occ_rdata | mask);
    occ_raddr = (state == S_MRD) ? row_addr(i[PI-1:0], mrow[RI-1:0])
                                 : row_addr(i[PI-1:0], row_sum[RI-1:0]);
    fs_we     = (state == S_BRFS) || (state == S_RFSW);
    if (state == S_BRFS) begin
      fs_wdata = FSW'(PAGE_AREA);
    end else if (18'(fs_rdata) > area) begin
      fs_wdata = FSW'(18'(fs_rdata) - area);
    end else begin
      fs_wdata = '0;
    end
  end

  ffrp_ram #(.WIDTH(PAGE_DIM), .DEPTH(MAX_PAGES * PAGE_DIM)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rdata)
  );

  ffrp_ram #(.WIDTH(FSW), .DEPTH(MAX_PAGES)) u_fs (
    .clk(clk), .we(fs_we), .waddr(i[PI-1:0]), .wdata(fs_wdata),
    .raddr(i[PI-1:0]), .rdata(fs_rdata)
  );

  ffrp_span #(.PAGE_DIM(PAGE_DIM)) u_span (
    .clk(clk), .rst(rst), .start(sp_start), .occ(c), .w(rw), .stat(sp_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lpc       <= ffrp_pkg::CFG_W'(1);
      pages     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lpc <= cfg_data;
      end
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data.opcode;
            rx    <= in_data.rect_x;
            ry    <= in_data.rect_y;
            rw    <= in_data.rect_w;
            rh    <= in_data.rect_h;
            area  <= in_data.rect_w * in_data.rect_h;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          r_status <= ffrp_pkg::ST_OK;
          r_page   <= '0;
          r_x      <= '0;
          r_y      <= '0;
          i        <= '0;
          cnt      <= '0;
          case (op)
            ffrp_pkg::OP_BEGIN: begin
              pages <= '0;
              state <= S_CLR;
            end
            ffrp_pkg::OP_RESERVE: begin
              mrow  <= {2'b0, ry};
              mend  <= ({2'b0, ry} + {1'b0, rh} > 10'(PAGE_DIM))
                       ? 10'(PAGE_DIM) : {2'b0, ry} + {1'b0, rh};
              mx    <= {2'b0, rx};
              mxe   <= ({2'b0, rx} + {1'b0, rw} > 10'(PAGE_DIM))
                       ? 10'(PAGE_DIM) : {2'b0, rx} + {1'b0, rw};
              state <= S_MCHK;
            end
            ffrp_pkg::OP_PLACE: begin
              if (area > 18'(PAGE_AREA)) begin
                r_status <= ffrp_pkg::ST_FULL;
                state    <= S_OUT;
              end else begin
                state <= S_PAGE;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_PAGE: begin
          if (pg_end) begin
            r_status <= ffrp_pkg::ST_FULL;
            state    <= S_OUT;
          end else if (i == pages) begin
            cnt   <= '0;
            state <= S_CLR;
          end else begin
            state <= S_FRD;
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == 10'(PAGE_DIM - 1)) begin
            state <= S_BRFS;
          end
        end
        S_BRFS: begin
          pages <= pages + 1'b1;
          state <= (op == ffrp_pkg::OP_BEGIN) ? S_OUT : S_FRD;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if ((18'(fs_rdata) < area) || (rw > 9'(PAGE_DIM)) || (rh > 9'(PAGE_DIM))) begin
            i     <= i + 1'b1;
            state <= S_PAGE;
          end else begin
            y     <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (y + {1'b0, rh} > 10'(PAGE_DIM)) begin
            i     <= i + 1'b1;
            state <= S_PAGE;
          end else if (rw == '0) begin
            // zero width fits at the left edge of the first row tried
            r_x   <= '0;
            r_y   <= y[7:0];
            mrow  <= y;
            mend  <= y + {1'b0, rh};
            mx    <= '0;
            mxe   <= '0;
            state <= S_MCHK;
          end else begin
            cnt   <= '0;
            c     <= '0;
            pend  <= 1'b0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          // one row read issued per cycle; read data lands in the next cycle
          if (cnt < {1'b0, rh}) begin
            cnt  <= cnt + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            c <= c | occ_rdata;
          end
          if (sp_start) begin
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (sp_stat.done) begin
            if (sp_stat.found) begin
              r_x   <= sp_stat.pos;
              r_y   <= y[7:0];
              mrow  <= y;
              mend  <= y + {1'b0, rh};
              mx    <= {2'b0, sp_stat.pos};
              mxe   <= {2'b0, sp_stat.pos} + {1'b0, rw};
              state <= S_MCHK;
            end else begin
              y     <= y + 1'b1;
              state <= S_ROW;
            end
          end
        end
        S_MCHK: begin
          if (mrow < mend) begin
            state <= S_MRD;
          end else if (op == ffrp_pkg::OP_RESERVE) begin
            state <= S_RFS;
          end else begin
            r_page <= 5'({2'b0, start_pg} + 8'(i));
            state  <= S_OUT;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          mrow  <= mrow + 1'b1;
          state <= S_MCHK;
        end
        S_RFS:  state <= S_RFSW;
        S_RFSW: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.status      <= r_status;
            out_data.page_index  <= (r_status == ffrp_pkg::ST_OK) ? r_page : 5'd0;
            out_data.pos_x       <= (r_status == ffrp_pkg::ST_OK) ? r_x : 8'd0;
            out_data.pos_y       <= (r_status == ffrp_pkg::ST_OK) ? r_y : 8'd0;
            out_data.added_pages <= (pages == '0) ? 5'd0 : 5'(pages - 1'b1);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pages_max: assert property (@(posedge clk) disable iff (rst)
    pages <= PW'(MAX_PAGES))
    else $error("pages in use above limit");

  a_span_done: assert property (@(posedge clk) disable iff (rst)
    sp_stat.done |-> state == S_SPAN)
    else $error("span result outside search");

  a_bring: assert property (@(posedge clk) disable iff (rst)
    state == S_BRFS |=> pages == PW'($past(pages) + 1'b1))
    else $error("page not added after clear");

  a_mark_row: assert property (@(posedge clk) disable iff (rst)
    state == S_MWR |-> mrow < mend)
    else $error("mark past last row");

endmodule
`default_nettype wire

/* src/ffrp_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ffrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/ffrp_span.sv */
// Free-run search: window AND by repeated shifts, then chunked first-set-bit scan.
`default_nettype none
module ffrp_span #(
  parameter int PAGE_DIM = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [PAGE_DIM-1:0]  occ,
  input  wire logic [8:0]           w,
  output ffrp_pkg::span_stat_t      stat
);

  localparam int CHUNK = 16;
  localparam int NCH   = (PAGE_DIM + CHUNK - 1) / CHUNK;
  localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [1:0] SP_IDLE = 2'd0;
  localparam logic [1:0] SP_AND  = 2'd1;
  localparam logic [1:0] SP_SRCH = 2'd2;

  logic [1:0]            state;
  logic [PAGE_DIM-1:0]   r;
  logic [8:0]            len;
  logic [CIW-1:0]        chk;
  logic [NCH*CHUNK-1:0]  rp;
  logic [CHUNK-1:0]      cb;
  logic [3:0]            lo;
  logic [8:0]            rem;
  logic [8:0]            s;

  assign rp  = (NCH*CHUNK)'(r);
  assign cb  = rp[chk*CHUNK +: CHUNK];
  assign rem = w - len;
  assign s   = (len < rem) ? len : rem;

  always_comb begin
    lo = 4'd0;
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (cb[k]) lo = 4'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SP_IDLE;
      stat.done  <= 1'b0;
      stat.found <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        SP_IDLE: begin
          if (start) begin
            r     <= ~occ;
            len   <= 9'd1;
            state <= SP_AND;
          end
        end
        SP_AND: begin
          // extend the free window from len to len+s texels
          if (len >= w) begin
            chk   <= '0;
            state <= SP_SRCH;
          end else begin
            r   <= r & (r >> s);
            len <= len + s;
          end
        end
        SP_SRCH: begin
          if (|cb) begin
            stat.done  <= 1'b1;
            stat.found <= 1'b1;
            stat.pos   <= ffrp_pkg::POS_W'({chk, lo});
            state      <= SP_IDLE;
          end else if (chk == CIW'(NCH - 1)) begin
            stat.done  <= 1'b1;
            stat.found <= 1'b0;
            state      <= SP_IDLE;
          end else begin
            chk <= chk + 1'b1;
          end
        end
        default: state <= SP_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/first_fit_rectangle_placer_test.sv */
// Testbench for the first-fit rectangle placer: random handshakes, predicted placements.
`timescale 1ns / 1ps
module first_fit_rectangle_placer_test;

  localparam int MAX_PAGES = 32;
  localparam int PAGE_DIM  = 256;
  localparam int PAGE_AREA = PAGE_DIM * PAGE_DIM;
  localparam longint CYCLE_LIMIT = 200_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffrp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffrp_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ffrp_pkg::CFG_W-1:0] cfg_data = '0;

  first_fit_rectangle_placer #(.MAX_PAGES(MAX_PAGES), .PAGE_DIM(PAGE_DIM)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow of the placer
  logic [PAGE_DIM-1:0] occ_map [MAX_PAGES][PAGE_DIM];
  int free_left [MAX_PAGES];
  int pages_used;
  int level_count;

  ffrp_pkg::in_item_t  pending_items [$];
  ffrp_pkg::out_item_t expected_results [$];
  int  fail_count = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_kick = 0;
  bit  hold_done = 0;
  longint cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic open_page();
    if (pages_used < MAX_PAGES) begin
      for (int r = 0; r < PAGE_DIM; r++) occ_map[pages_used][r] = '0;
      free_left[pages_used] = PAGE_AREA;
      pages_used++;
    end
  endtask

  task automatic mark_area(int pg, int x, int y, int w, int h);
    int xe, ye;
    xe = (x + w > PAGE_DIM) ? PAGE_DIM : x + w;
    ye = (y + h > PAGE_DIM) ? PAGE_DIM : y + h;
    for (int r = y; r < ye; r++)
      for (int c = x; c < xe; c++) occ_map[pg][r][c] = 1'b1;
  endtask

  function automatic bit find_free_spot(int pg, int w, int h, output int px, output int py);
    logic [PAGE_DIM-1:0] cols;
    int run;
    px = 0;
    py = 0;
    if (w > PAGE_DIM || h > PAGE_DIM) return 1'b0;
    for (int y = 0; y + h <= PAGE_DIM; y++) begin
      if (w == 0) begin
        py = y;
        return 1'b1;
      end
      cols = '0;
      for (int r = y; r < y + h; r++) cols |= occ_map[pg][r];
      run = 0;
      for (int x = 0; x < PAGE_DIM; x++) begin
        if (cols[x]) run = 0;
        else begin
          run++;
          if (run == w) begin
            px = x + 1 - w;
            py = y;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_placement(ffrp_pkg::in_item_t it);
    ffrp_pkg::out_item_t res;
    int first_pg, allowed, area, px, py, w, h;
    res = '0;
    first_pg = (level_count == 0) ? 0 : level_count - 1;
    allowed = (first_pg < MAX_PAGES) ? MAX_PAGES - first_pg : 0;
    w = it.rect_w;
    h = it.rect_h;
    area = w * h;
    case (it.opcode)
      ffrp_pkg::OP_BEGIN: begin
        pages_used = 0;
        open_page();
      end
      ffrp_pkg::OP_RESERVE: begin
        mark_area(0, it.rect_x, it.rect_y, w, h);
        free_left[0] = (free_left[0] > area) ? free_left[0] - area : 0;
      end
      ffrp_pkg::OP_PLACE: begin
        res.status = ffrp_pkg::ST_FULL;
        if (area <= PAGE_AREA) begin
          for (int i = 0; i < allowed; i++) begin
            if (i == pages_used) open_page();
            if (free_left[i] < area) continue;
            if (find_free_spot(i, w, h, px, py)) begin
              mark_area(i, px, py, w, h);
              res.status = ffrp_pkg::ST_OK;
              res.page_index = 5'(first_pg + i);
              res.pos_x = 8'(px);
              res.pos_y = 8'(py);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    res.added_pages = 5'((pages_used > 0) ? pages_used - 1 : 0);
    expected_results.push_back(res);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_placement(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (hold_kick && !hold_done) begin
      hold_left <= 800;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    ffrp_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_data.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, out_data.status);
            fail_count++;
          end
          if (want.page_index !== out_data.page_index) begin
            $display("%0t: page_index exp %0d got %0d", $time, want.page_index,
                     out_data.page_index);
            fail_count++;
          end
          if (want.pos_x !== out_data.pos_x) begin
            $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, out_data.pos_x);
            fail_count++;
          end
          if (want.pos_y !== out_data.pos_y) begin
            $display("%0t: pos_y exp %0d got %0d", $time, want.pos_y, out_data.pos_y);
            fail_count++;
          end
          if (want.added_pages !== out_data.added_pages) begin
            $display("%0t: added_pages exp %0d got %0d", $time, want.added_pages,
                     out_data.added_pages);
            fail_count++;
          end
        end
        out_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (hold_left > 0) out_ready <= 1'b0;
      else if (out_gap > 0 && !(out_valid && out_ready)) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!(out_valid && out_ready)) out_ready <= 1'b1;
      else out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic ffrp_pkg::in_item_t make_item(logic [1:0] op, int x, int y, int w, int h);
    ffrp_pkg::in_item_t it;
    it.opcode = op;
    it.rect_x = 8'(x);
    it.rect_y = 8'(y);
    it.rect_w = 9'(w);
    it.rect_h = 9'(h);
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_level(int v);
    cfg_valid <= 1'b1;
    cfg_data <= ffrp_pkg::CFG_W'(v);
    do @(posedge clk);
    while (!cfg_ready);
    level_count = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int n);
    int pick, w, h;
    pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, 0, 0, 1, 1));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)
        pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, $urandom_range(0, 255),
                                          $urandom_range(0, 255), 1, 1));
      else if (pick < 24)
        pending_items.push_back(make_item(ffrp_pkg::OP_RESERVE, $urandom_range(0, 255),
                                          $urandom_range(0, 255), $urandom_range(1, 64),
                                          $urandom_range(1, 64)));
      else if (pick < 27)
        pending_items.push_back(make_item(ffrp_pkg::OP_NOP, $urandom_range(0, 255),
                                          $urandom_range(0, 255), $urandom_range(0, 511),
                                          $urandom_range(0, 511)));
      else begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(1, 256);
          h = $urandom_range(1, 256);
        end else begin
          w = $urandom_range(1, 24);
          h = $urandom_range(1, 24);
        end
        pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, $urandom_range(0, 255),
                                          $urandom_range(0, 255), w, h));
      end
    end
  endtask

  initial begin
    for (int p = 0; p < MAX_PAGES; p++) begin
      for (int r = 0; r < PAGE_DIM; r++) occ_map[p][r] = '0;
      free_left[p] = 0;
    end
    pages_used = 0;
    level_count = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // place before any begin, edge reserves, zero sizes, oversize, saturation
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 4, 4));
    pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, 0, 0, 1, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_RESERVE, 0, 0, 256, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_RESERVE, 250, 250, 20, 20));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 8, 8));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 0, 5));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 3, 0));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 256, 257));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 257, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 511, 0));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 0, 511));
    pending_items.push_back(make_item(ffrp_pkg::OP_RESERVE, 255, 255, 511, 511));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 1, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_NOP, 255, 255, 511, 511));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 255, 255, 256, 256));
    pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, 0, 0, 1, 1));
    wait_idle();

    // level count past the page limit: every place fails
    write_level(33);
    pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, 0, 0, 1, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 2, 2));
    pending_items.push_back(make_item(ffrp_pkg::OP_RESERVE, 10, 10, 5, 5));
    wait_idle();
    write_level(0);
    pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, 0, 0, 1, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 5, 5));
    wait_idle();
    // single packing page
    write_level(32);
    pending_items.push_back(make_item(ffrp_pkg::OP_BEGIN, 0, 0, 1, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 1, 1));
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 256, 256));
    wait_idle();
    write_level(63);
    pending_items.push_back(make_item(ffrp_pkg::OP_PLACE, 0, 0, 1, 1));
    wait_idle();

    write_level(1);
    hold_kick = 1'b1;
    queue_random(57);
    wait_idle();
    write_level(30);
    queue_random(57);
    wait_idle();
    repeat (200) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
